>>> rtl/core/distance_vector_table_update_core_macros.svh
// assertion macros for the distance vector table update core
// used by distance_vector_table_update_core.sv, no other dependencies
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DVTU_ASSERT_NOW(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DVTU_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/dvtu_pkg.sv
// shared types and constants for the distance vector table update core
// no dependencies
`default_nettype none

package dvtu_pkg;

    localparam int MAX_NODES  = 16;
    localparam int NODE_BITS  = 4;
    localparam int COST_BITS  = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    // operation codes carried in the input beat
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ADVERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_LOWER  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_LOWER = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_NODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NEIGHBORS  = 2'd2;

    // one routing table entry
    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic                 known;
        logic [NODE_BITS-1:0] hop;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/dvtu_table_ram.sv
// routing table storage: one write port, two registered read ports
// depends on dvtu_pkg for the entry type and depth
`default_nettype none

module dvtu_table_ram
    import dvtu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [NODE_BITS-1:0] wr_addr,
    input  wire entry_t               wr_data,
    input  wire logic                 rd_en,
    input  wire logic [NODE_BITS-1:0] rd_addr_a,
    input  wire logic [NODE_BITS-1:0] rd_addr_b,
    output entry_t                    rd_data_a,
    output entry_t                    rd_data_b
);

    entry_t table_mem [MAX_NODES];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    // read ports, old data on a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= table_mem[rd_addr_a];
            rd_b_reg <= table_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

>>> rtl/core/distance_vector_table_update_core.sv
// distance vector routing table update core, top level
// depends on dvtu_pkg, dvtu_table_ram and the assertion macro header
//
// usage:
//   input beats (s_ channel) carry one table operation each: load link cost,
//   advertisement entry, route query or lower link cost. every beat yields
//   exactly one result beat on the m_ channel with the touched entry, the
//   send request flag and a status code.
//   configuration (own node, node count, neighbor mask) is written through
//   cfg_we / cfg_index / cfg_wdata while the core is idle.
// timing:
//   a beat accepted at one clock edge reads its two table entries from the
//   table ram at that edge, as the input stage loads; the update is
//   computed from them and the result register loads when the result stage
//   is free, which a low m_tready can hold off. one beat per cycle is kept up
//   while m_tready is high; the ram ports with write forwarding allow it.
// reset:
//   aresetn (synchronous, active low) clears both channel stages, own node,
//   neighbor mask and all per-entry flags and sets node count to MAX_NODES-1;
//   every entry then reads as unknown, cost 0, next hop 0, no clearing pass.
// stall:
//   when m_tready is low with a result waiting, the core still holds one
//   accepted beat in its input stage, then drops s_tready.
`default_nettype none

`include "distance_vector_table_update_core_macros.svh"

module distance_vector_table_update_core
    import dvtu_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_wdata,
    // input channel
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [23:0]             s_tdata,   // source_node, dest_node, cost_value
    input  wire logic [2:0]              s_tuser,   // op, cost_valid
    input  wire logic                    s_tlast,   // last_entry
    // result channel
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata,   // route_cost, route_known, next_hop, zeros
    output logic [2:0]                   m_tuser    // send_request, status
);

    // configuration registers
    logic [NODE_BITS-1:0] own_node_reg;
    logic [NODE_BITS-1:0] node_count_reg;
    logic [MAX_NODES-1:0] neighbor_mask_reg;

    // input stage
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic [NODE_BITS-1:0] in_src_reg;
    logic [NODE_BITS-1:0] in_dst_reg;
    logic [COST_BITS-1:0] in_cost_reg;
    logic                 in_cvalid_reg;
    logic                 in_last_reg;

    // per-entry flags: written at least once, forced to own entry by a load
    logic [MAX_NODES-1:0] written_reg;
    logic [MAX_NODES-1:0] own_ovr_reg;
    logic [MAX_NODES-1:0] own_ovr_next;

    // last table write, for the read issued at the same edge
    logic                 fwd_en_reg;
    logic [NODE_BITS-1:0] fwd_addr_reg;
    entry_t               fwd_data_reg;

    logic                 pending_reg;
    logic                 pending_next;

    // result stage
    logic                 out_valid_reg;
    entry_t               out_entry_reg;
    logic                 out_send_reg;
    status_t              out_status_reg;
    entry_t               out_entry_next;
    logic                 out_send_next;
    status_t              out_status_next;

    // handshakes
    logic                 fire;
    logic                 s_accept;

    // table access
    entry_t               ram_q_dst;
    entry_t               ram_q_src;
    entry_t               dst_entry;
    entry_t               src_entry;
    entry_t               own_entry;
    logic                 wr_en;
    entry_t               wr_data;
    logic                 ovr_set;

    // update datapath
    logic                 dst_ok;
    logic                 src_ok;
    logic [COST_BITS:0]   sum_wide;
    logic [COST_BITS-1:0] total;
    logic                 changed;
    entry_t               relax_entry;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_node_reg      <= '0;
            node_count_reg    <= NODE_BITS'(MAX_NODES - 1);
            neighbor_mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OWN_NODE:   own_node_reg      <= cfg_wdata[NODE_BITS-1:0];
                CFG_NODE_COUNT: node_count_reg    <= cfg_wdata[NODE_BITS-1:0];
                CFG_NEIGHBORS:  neighbor_mask_reg <= cfg_wdata[MAX_NODES-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= op_t'(s_tuser[1:0]);
            in_cvalid_reg <= s_tuser[2];
            in_src_reg    <= s_tdata[3:0];
            in_dst_reg    <= s_tdata[7:4];
            in_cost_reg   <= s_tdata[23:8];
            in_last_reg   <= s_tlast;
        end
    end

    dvtu_table_ram u_table (
        .aclk      (aclk),
        .wr_en     (fire && wr_en),
        .wr_addr   (in_dst_reg),
        .wr_data   (wr_data),
        .rd_en     (s_accept),
        .rd_addr_a (s_tdata[7:4]),
        .rd_addr_b (s_tdata[3:0]),
        .rd_data_a (ram_q_dst),
        .rd_data_b (ram_q_src)
    );

    // resolve one entry: own override, never written, forwarded write, ram
    function automatic entry_t resolve(
        input logic [NODE_BITS-1:0] addr,
        input entry_t               ram_q,
        input logic [MAX_NODES-1:0] written,
        input logic [MAX_NODES-1:0] own_ovr,
        input logic                 fwd_en,
        input logic [NODE_BITS-1:0] fwd_addr,
        input entry_t               fwd_data
    );
        entry_t e;
        if (own_ovr[addr]) begin
            e.cost  = '0;
            e.known = 1'b1;
            e.hop   = addr;
        end else if (!written[addr]) begin
            e = '0;
        end else if (fwd_en && fwd_addr == addr) begin
            e = fwd_data;
        end else begin
            e = ram_q;
        end
        return e;
    endfunction

    assign dst_entry = resolve(in_dst_reg, ram_q_dst, written_reg, own_ovr_reg,
                               fwd_en_reg, fwd_addr_reg, fwd_data_reg);
    assign src_entry = resolve(in_src_reg, ram_q_src, written_reg, own_ovr_reg,
                               fwd_en_reg, fwd_addr_reg, fwd_data_reg);

    assign own_entry.cost  = '0;
    assign own_entry.known = 1'b1;
    assign own_entry.hop   = own_node_reg;

    // node numbers are always below MAX_NODES at this field width
    assign dst_ok = in_dst_reg <= node_count_reg;
    assign src_ok = in_src_reg <= node_count_reg;

    // saturating relaxation sum
    assign sum_wide = {1'b0, in_cost_reg} + {1'b0, src_entry.cost};
    assign total    = sum_wide[COST_BITS] ? COST_MAX : sum_wide[COST_BITS-1:0];

    // advertisement relaxation
    always_comb begin
        changed     = 1'b0;
        relax_entry = dst_entry;
        if (in_dst_reg != in_src_reg && in_cvalid_reg && src_ok && src_entry.known) begin
            if (!dst_entry.known || dst_entry.cost > total) begin
                relax_entry.cost  = total;
                relax_entry.known = 1'b1;
                relax_entry.hop   = in_src_reg;
                changed           = 1'b1;
            end else if (dst_entry.hop == in_src_reg && dst_entry.cost < total) begin
                relax_entry.cost = total;
                changed          = 1'b1;
            end
        end
    end

    // per-operation update and result
    always_comb begin
        wr_en           = 1'b0;
        wr_data         = dst_entry;
        ovr_set         = 1'b0;
        pending_next    = pending_reg;
        out_entry_next  = dst_entry;
        out_send_next   = 1'b0;
        out_status_next = ST_DONE;
        if (!dst_ok) begin
            out_entry_next  = '0;
            out_status_next = ST_REJECT;
        end else begin
            unique case (in_op_reg)
                OP_LOAD: begin
                    wr_en         = 1'b1;
                    wr_data.cost  = in_cvalid_reg ? in_cost_reg : '0;
                    wr_data.known = in_cvalid_reg;
                    wr_data.hop   = in_dst_reg;
                    ovr_set       = 1'b1;
                    out_entry_next = (in_dst_reg == own_node_reg) ? own_entry : wr_data;
                end
                OP_ADVERT: begin
                    wr_en          = changed;
                    wr_data        = relax_entry;
                    out_entry_next = relax_entry;
                    if (in_last_reg) begin
                        out_send_next = pending_reg || changed;
                        pending_next  = 1'b0;
                    end else if (changed) begin
                        pending_next = 1'b1;
                    end
                end
                OP_QUERY: begin
                end
                OP_LOWER: begin
                    if (in_src_reg != own_node_reg || in_dst_reg == own_node_reg
                        || !neighbor_mask_reg[in_dst_reg]) begin
                        out_status_next = ST_REJECT;
                    end else if (!dst_entry.known || !in_cvalid_reg
                                 || !(dst_entry.cost > in_cost_reg)) begin
                        out_status_next = ST_NOT_LOWER;
                    end else begin
                        wr_en          = 1'b1;
                        wr_data.cost   = in_cost_reg;
                        wr_data.hop    = in_dst_reg;
                        out_entry_next = wr_data;
                        out_send_next  = 1'b1;
                        pending_next   = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // own entry override flags after this beat
    always_comb begin
        own_ovr_next = own_ovr_reg;
        if (wr_en) begin
            own_ovr_next[in_dst_reg] = 1'b0;
        end
        // own entry set after the destination write so it wins
        if (ovr_set) begin
            own_ovr_next[own_node_reg] = 1'b1;
        end
    end

    // table flags, forwarding and pending change
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            own_ovr_reg <= '0;
            fwd_en_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end else if (fire) begin
            pending_reg <= pending_next;
            own_ovr_reg <= own_ovr_next;
            if (wr_en) begin
                written_reg[in_dst_reg] <= 1'b1;
                fwd_en_reg              <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && wr_en) begin
            fwd_addr_reg <= in_dst_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_entry_reg  <= out_entry_next;
            out_send_reg   <= out_send_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_entry_reg.hop, out_entry_reg.known, out_entry_reg.cost};
    assign m_tuser  = {out_status_reg, out_send_reg};

    // checks
    `DVTU_ASSERT_NEXT(a_range_reject, aclk, aresetn, fire && !dst_ok,
        out_valid_reg && out_status_reg == ST_REJECT && out_entry_reg == '0,
        "out of range destination not rejected")
    `DVTU_ASSERT_NOW(a_send_done, aclk, aresetn, out_valid_reg && out_send_reg,
        out_status_reg == ST_DONE, "send request with non-done status")
    `DVTU_ASSERT_NEXT(a_send_clears, aclk, aresetn, fire && out_send_next,
        !pending_reg, "pending change kept after send request")
    `DVTU_ASSERT_NEXT(a_load_own, aclk, aresetn, fire && dst_ok && in_op_reg == OP_LOAD,
        own_ovr_reg[$past(own_node_reg)], "own entry not forced by load")

endmodule

`default_nettype wire
